@@ hdl/cmac_pkg.sv @@
`default_nettype none
package cmac_pkg;

   localparam int BLOCK_BITS = 128;
   localparam int WORD_BITS  = 64;
   localparam int QUEUE_DEPTH = 2;

   // Register byte addresses.
   localparam logic [3:0] CSR_KEY_HIGH = 4'h0;
   localparam logic [3:0] CSR_KEY_LOW  = 4'h8;

   localparam logic [4:0] FULL_BLOCK_BYTES = 5'd16;
   localparam logic [3:0] WORD_BYTES       = 4'd8;
   localparam logic [7:0] GF_POLY          = 8'h87;
   localparam logic [7:0] PAD_BYTE         = 8'h80;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        final_word;
   } req_item_type;

   typedef struct packed {
      logic [63:0] mac_half;
      logic        last_half;
   } rsp_item_type;

   // One block of work for the cipher side.
   typedef struct packed {
      logic         last;
      logic [4:0]   nbytes;
      logic [127:0] block;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Next round key from the current one.
   function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, tw, n0, n1, n2, n3;
      w0 = rk[127:96];
      w1 = rk[95:64];
      w2 = rk[63:32];
      w3 = rk[31:0];
      tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      n0 = w0 ^ tw;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // SubBytes, ShiftRows and, except in the last round, MixColumns.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
            t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8 * i -: 8] = t[i];
      end
      return r;
   endfunction

   function automatic logic [127:0] gf_double(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'b0, (v[127] ? GF_POLY : 8'h00)};
   endfunction

endpackage
`default_nettype wire

@@ hdl/cmac_aes.sv @@
`default_nettype none
module cmac_aes (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] din,
   input  wire logic [127:0] key,
   output logic              busy,
   output logic              done,
   output logic [127:0]      dout
);
   import cmac_pkg::*;

   localparam logic [3:0] LAST_ROUND = 4'd10;

   logic [127:0] st_ff, st_in, rk_ff, rk_in, nk;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in, done_ff, done_in;

   // One round per cycle; the round key is expanded alongside.
   always_comb begin
      st_in    = st_ff;
      rk_in    = rk_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      nk       = key_step(rk_ff, rcon_ff);
      if (start) begin
         st_in    = din ^ key;
         rk_in    = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         st_in    = aes_round(st_ff, round_ff == LAST_ROUND) ^ nk;
         rk_in    = nk;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff    <= st_in;
      rk_ff    <= rk_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign dout = st_ff;

endmodule
`default_nettype wire

@@ hdl/cmac_front.sv @@
`default_nettype none
module cmac_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire cmac_pkg::req_item_type req_item,
   output logic                       req_stall,
   input  wire logic                  q_space,
   output logic                       push,
   output cmac_pkg::cmd_type          push_cmd
);
   import cmac_pkg::*;

   logic [127:0] pend_ff, pend_in;
   logic [4:0]   pbytes_ff, pbytes_in;
   logic         hold_v_ff, hold_v_in;
   cmd_type      hold_ff, hold_in;
   logic         acc;
   logic [3:0]   n;
   logic [63:0]  word_m;

   // A full pending block is only chained once a later word proves it is
   // not the last one; a final word may then need a second command, which
   // waits in the hold register while the input is stalled.
   always_comb begin
      acc = req_valid && !req_stall;
      if (!req_item.final_word || req_item.byte_count > WORD_BYTES) begin
         n = WORD_BYTES;
      end else begin
         n = req_item.byte_count;
      end
      word_m    = req_item.data_word & ~({WORD_BITS{1'b1}} >> {n, 3'b000});
      pend_in   = pend_ff;
      pbytes_in = pbytes_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      push      = 1'b0;
      push_cmd  = '0;
      if (hold_v_ff && q_space) begin
         push      = 1'b1;
         push_cmd  = hold_ff;
         hold_v_in = 1'b0;
      end
      if (acc) begin
         if (n != 4'd0) begin
            if (pbytes_ff == FULL_BLOCK_BYTES) begin
               push      = 1'b1;
               push_cmd  = '{last: 1'b0, nbytes: FULL_BLOCK_BYTES, block: pend_ff};
               pend_in   = {word_m, 64'b0};
               pbytes_in = {1'b0, n};
            end else if (pbytes_ff[3]) begin
               pend_in[63:0] = word_m;
               pbytes_in     = pbytes_ff + {1'b0, n};
            end else begin
               pend_in[127:64] = word_m;
               pbytes_in       = {1'b0, n};
            end
         end
         if (req_item.final_word) begin
            if (push) begin
               hold_v_in = 1'b1;
               hold_in   = '{last: 1'b1, nbytes: pbytes_in, block: pend_in};
            end else begin
               push     = 1'b1;
               push_cmd = '{last: 1'b1, nbytes: pbytes_in, block: pend_in};
            end
            pend_in   = '0;
            pbytes_in = '0;
         end
      end
   end

   assign req_stall = hold_v_ff || !q_space;

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) begin
         pend_ff   <= '0;
         pbytes_ff <= '0;
         hold_v_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         pbytes_ff <= pbytes_in;
         hold_v_ff <= hold_v_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cmac_queue.sv @@
`default_nettype none
module cmac_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cmac_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output cmac_pkg::cmd_type      head,
   output cmac_pkg::queue_status_type status
);
   import cmac_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type          ent_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + PW'(1);
         end
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   assign head         = ent_ff[rd_ff];
   assign status.full  = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign status.empty = cnt_ff == '0;

endmodule
`default_nettype wire

@@ hdl/cmac_back.sv @@
`default_nettype none
module cmac_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [127:0]           key,
   input  wire logic                   key_write,
   input  wire cmac_pkg::cmd_type      head,
   input  wire cmac_pkg::queue_status_type q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   output cmac_pkg::rsp_item_type      rsp_item,
   input  wire logic                   rsp_stall
);
   import cmac_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SUBKEY = 2'd1;
   localparam logic [1:0] ST_BLOCK  = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [127:0] chain_ff, chain_in, k1_ff, k1_in, k2_ff, k2_in, mac_ff, mac_in;
   logic         ready_ff, ready_in, cur_last_ff, cur_last_in;
   logic [1:0]   out_cnt_ff, out_cnt_in;
   logic         aes_start, aes_busy, aes_done;
   logic [127:0] aes_din, aes_dout, blk_x, pad;

   cmac_aes u_aes (
      .clock (clock),
      .reset (reset),
      .start (aes_start),
      .din   (aes_din),
      .key   (key),
      .busy  (aes_busy),
      .done  (aes_done),
      .dout  (aes_dout)
   );

   always_comb begin
      pad = head.block | ({PAD_BYTE, 120'b0} >> {head.nbytes, 3'b000});
      if (!head.last) begin
         blk_x = head.block;
      end else if (head.nbytes == FULL_BLOCK_BYTES) begin
         blk_x = head.block ^ k1_ff;
      end else begin
         blk_x = pad ^ k2_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      k1_in       = k1_ff;
      k2_in       = k2_ff;
      mac_in      = mac_ff;
      ready_in    = ready_ff;
      cur_last_in = cur_last_ff;
      out_cnt_in  = out_cnt_ff;
      aes_start   = 1'b0;
      aes_din     = '0;
      pop         = 1'b0;
      if (rsp_valid && !rsp_stall) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && !aes_busy) begin
               if (!ready_ff) begin
                  aes_start = 1'b1;
                  state_in  = ST_SUBKEY;
               end else if (!head.last || out_cnt_ff == 2'd0) begin
                  aes_start   = 1'b1;
                  aes_din     = chain_ff ^ blk_x;
                  pop         = 1'b1;
                  cur_last_in = head.last;
                  state_in    = ST_BLOCK;
               end
            end
         end
         ST_SUBKEY: begin
            if (aes_done) begin
               k1_in    = gf_double(aes_dout);
               k2_in    = gf_double(gf_double(aes_dout));
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BLOCK: begin
            if (aes_done) begin
               if (cur_last_ff) begin
                  mac_in     = aes_dout;
                  out_cnt_in = 2'd2;
                  chain_in   = '0;
               end else begin
                  chain_in = aes_dout;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (key_write) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      mac_ff      <= mac_in;
      cur_last_ff <= cur_last_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         chain_ff   <= '0;
         ready_ff   <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         ready_ff   <= ready_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   assign rsp_valid          = out_cnt_ff != 2'd0;
   assign rsp_item.mac_half  = out_cnt_ff[1] ? mac_ff[127:64] : mac_ff[63:0];
   assign rsp_item.last_half = out_cnt_ff == 2'd1;

endmodule
`default_nettype wire

@@ hdl/aes_cmac_engine.sv @@
// Each AES-128 block goes through the round unit as a start cycle, ten rounds
// and a done cycle, and the cipher side works on one block at a time; a full
// block takes two input words. The first MAC half comes sooner when the final
// word closes the only waiting block than when a full block is chained ahead
// of it, and the first word after reset or a key write also waits for the
// subkeys. Reset is synchronous and active high; it clears the key, the
// chaining state and the handshakes. Subkeys are rederived after reset and
// after key writes.
`default_nettype none
module aes_cmac_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire cmac_pkg::req_item_type req_item,
   output logic                        req_stall,
   output logic                        rsp_valid,
   output cmac_pkg::rsp_item_type      rsp_item,
   input  wire logic                   rsp_stall,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [3:0]             paddr,
   input  wire logic [63:0]            pwdata,
   output logic [63:0]                 prdata,
   output logic                        pready
);
   import cmac_pkg::*;

   logic [63:0]      key_high_ff, key_low_ff;
   logic             wr_en, key_write;
   logic             push, pop;
   cmd_type          push_cmd, head;
   queue_status_type q_status;

   // The register port has no wait states. A write to either key half
   // marks the subkeys stale so that the cipher side derives them again.
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign key_write = wr_en && (paddr == CSR_KEY_HIGH || paddr == CSR_KEY_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (wr_en) begin
         if (paddr == CSR_KEY_HIGH) begin
            key_high_ff <= pwdata;
         end
         if (paddr == CSR_KEY_LOW) begin
            key_low_ff <= pwdata;
         end
      end
   end

   always_comb begin
      case (paddr)
         CSR_KEY_HIGH: prdata = key_high_ff;
         CSR_KEY_LOW:  prdata = key_low_ff;
         default:      prdata = '0;
      endcase
   end

   // The front assembles words into blocks and decides which block is the
   // last one of the message; the queue lets it keep taking words while the
   // cipher side is busy with an earlier block.
   cmac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .q_space   (!q_status.full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   cmac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // The back chains blocks through the round unit and holds the finished
   // tag in its own output register, two items long.
   cmac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key       ({key_high_ff, key_low_ff}),
      .key_write (key_write),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

   // No result can be pending right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Once the high half is taken, the low half follows at once.
   a_second_half: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_item.last_half) |=> (rsp_valid && rsp_item.last_half))
      else $error("second MAC half missing");

   // A full queue must hold off the input.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> req_stall)
      else $error("input accepted while queue full");

   // Nothing is taken from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue underflow");

endmodule
`default_nettype wire
